// File: src/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, register codes and interface types of the symmetric
// FIR smoothing block.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 4;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int WEIGHT_BITS     = 10;
    localparam int WEIGHT_COUNT    = 5;
    localparam int WEIGHT_IDX_W    = 3;
    localparam int HALF_WIDTH_BITS = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RST = 3'd2;
    localparam logic [WEIGHT_BITS-1:0]     WEIGHT_RST     = 10'sd1;

    typedef enum logic [2:0] {
        REG_HALF_WIDTH   = 3'd0,
        REG_CAUSAL_MODE  = 3'd1,
        REG_WEIGHT_CTR   = 3'd2,
        REG_WEIGHT_ONE   = 3'd3,
        REG_WEIGHT_TWO   = 3'd4,
        REG_WEIGHT_THREE = 3'd5,
        REG_WEIGHT_FOUR  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [HALF_WIDTH_BITS-1:0]                  half_width;
        logic                                        causal_mode;
        logic [WEIGHT_COUNT-1:0][WEIGHT_BITS-1:0]    weight;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mac_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_tap;
        logic div_last;
    } dp_status_t;

endpackage

// File: src/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer: tap accumulation, serial divide and output register handshake.
// ----------------------------------------------------------------------------
module sfs_ctrl
    import sfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DIV_INIT,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.last_tap)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_MAC)
        else $error("accepted transfer did not start accumulation");

    a_mac_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC && !status.last_tap |=> state_reg == S_MAC)
        else $error("accumulation left before last tap");

    a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVIDE && !status.div_last |=> state_reg == S_DIVIDE)
        else $error("divide left before last step");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && slot_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not registered on free output slot");

endmodule

// File: src/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// Delay line, shared multiply-accumulate, restoring divider and saturating
// output register.
// ----------------------------------------------------------------------------
module sfs_datapath
    import sfs_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          zero_weight_error
);

    localparam int NT    = 2 * MAX_HALF_WIDTH + 1;
    localparam int TAP_W = $clog2(NT);
    localparam int HW_W  = $clog2(MAX_HALF_WIDTH + 1);
    localparam int ACC_W = SAMPLE_BITS + WEIGHT_BITS + TAP_W;
    localparam int WS_W  = WEIGHT_BITS + TAP_W;
    localparam int CNT_W = $clog2(ACC_W);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);
    localparam logic [ACC_W-1:0] Q_POS_LIM = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] Q_NEG_LIM = ACC_W'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic [SAMPLE_BITS-1:0] hist_reg [NT];
    logic [TAP_W-1:0]       tap_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [WS_W-1:0]  wsum_reg;
    logic [ACC_W-1:0]       quo_reg;
    logic [WS_W-1:0]        rem_reg;
    logic [WS_W-1:0]        divisor_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] smoothed_reg;
    logic                   zero_out_reg;

    logic [HW_W-1:0]        h_eff;
    logic [TAP_W-1:0]       h_tap;
    logic [TAP_W-1:0]       last_tap;
    logic [TAP_W-1:0]       pos;
    logic [TAP_W-1:0]       tap_dist;
    logic [WEIGHT_IDX_W-1:0] widx;
    logic signed [WEIGHT_BITS-1:0] w;
    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [SAMPLE_BITS+WEIGHT_BITS-1:0] prod;
    logic [ACC_W-1:0]       acc_mag;
    logic [WS_W-1:0]        wsum_mag;
    logic [WS_W:0]          shifted;
    logic [WS_W:0]          diff;
    logic [SAMPLE_BITS-1:0] q_low;
    logic [SAMPLE_BITS-1:0] result;

    // effective half width and tap geometry
    always_comb
    begin
        if (int'(cfg.half_width) > MAX_HALF_WIDTH)
        begin
            h_eff = HW_W'(MAX_HALF_WIDTH);
        end
        else
        begin
            h_eff = HW_W'(cfg.half_width);
        end
        h_tap    = TAP_W'(h_eff);
        last_tap = cfg.causal_mode ? h_tap : TAP_W'(h_tap << 1);
        if (tap_reg <= h_tap)
        begin
            pos      = h_tap - tap_reg;
            tap_dist = h_tap - tap_reg;
        end
        else
        begin
            pos      = '0;
            tap_dist = tap_reg - h_tap;
        end
        widx = (int'(tap_dist) > WEIGHT_COUNT - 1) ? WEIGHT_IDX_W'(WEIGHT_COUNT - 1)
                                                   : WEIGHT_IDX_W'(tap_dist);
    end

    assign w    = $signed(cfg.weight[widx]);
    assign s    = $signed(hist_reg[pos]);
    assign prod = w * s;

    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign wsum_mag = wsum_reg[WS_W-1] ? WS_W'(-wsum_reg) : WS_W'(wsum_reg);

    assign shifted = {rem_reg, quo_reg[ACC_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    // sign, saturation and zero-weight handling of the quotient magnitude
    assign q_low = quo_reg[SAMPLE_BITS-1:0];
    always_comb
    begin
        if (zero_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = (quo_reg > Q_NEG_LIM) ? S_MIN : SAMPLE_BITS'(-q_low);
        end
        else
        begin
            result = (quo_reg > Q_POS_LIM) ? S_MAX : q_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            hist_reg[0] <= sample_in;
            for (int i = 1; i < NT; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tap_reg  <= '0;
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            tap_reg  <= tap_reg + TAP_W'(1);
            acc_reg  <= acc_reg + ACC_W'(prod);
            wsum_reg <= wsum_reg + WS_W'(w);
        end

        if (cmd.div_init)
        begin
            quo_reg     <= acc_mag;
            rem_reg     <= '0;
            divisor_reg <= wsum_mag;
            neg_reg     <= acc_reg[ACC_W-1] ^ wsum_reg[WS_W-1];
            zero_reg    <= (wsum_reg == '0);
            cnt_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (!diff[WS_W])
            begin
                rem_reg <= diff[WS_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WS_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            smoothed_reg <= result;
            zero_out_reg <= zero_reg;
        end
    end

    assign status.last_tap = (tap_reg == last_tap);
    assign status.div_last = (cnt_reg == CNT_LAST);

    assign smoothed          = $signed(smoothed_reg);
    assign zero_weight_error = zero_out_reg;

endmodule

// File: src/symmetric_fir_smoothing.sv
// ----------------------------------------------------------------------------
// symmetric_fir_smoothing
// Normalised symmetric FIR smoothing filter with APB register port.
// ----------------------------------------------------------------------------
// Operation: the accepted sample is accumulated over T taps, where T is the
//   tap count (2*h+1, or h+1 causal), then divided over W quotient bits, where
//   W = SAMPLE_BITS+10+clog2(2*MAX_HALF_WIDTH+1) is the divide length (30 by default).
// Throughput is set by the one-bit-per-cycle divider and the single shared
//   multiply-accumulate; a new sample waits until the last result is registered.
// Reset: delay line zeroed; half width 2, symmetric, all weights 1.
module symmetric_fir_smoothing
    import sfs_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          zero_weight_error,
    output logic                          out_valid,
    input  logic                          out_ready
);

    logic [HALF_WIDTH_BITS-1:0]               half_width_reg;
    logic                                     causal_mode_reg;
    logic [WEIGHT_COUNT-1:0][WEIGHT_BITS-1:0] weight_reg;
    logic                                     wr_en;
    reg_idx_t                                 idx;
    cfg_t                                     cfg;
    dp_cmd_t                                  cmd;
    dp_status_t                               status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= HALF_WIDTH_RST;
            causal_mode_reg <= 1'b0;
            for (int i = 0; i < WEIGHT_COUNT; i++)
            begin
                weight_reg[i] <= WEIGHT_RST;
            end
        end
        else if (wr_en)
        begin
            case (idx)
                REG_HALF_WIDTH:   half_width_reg  <= pwdata[HALF_WIDTH_BITS-1:0];
                REG_CAUSAL_MODE:  causal_mode_reg <= pwdata[0];
                REG_WEIGHT_CTR:   weight_reg[0]   <= pwdata[WEIGHT_BITS-1:0];
                REG_WEIGHT_ONE:   weight_reg[1]   <= pwdata[WEIGHT_BITS-1:0];
                REG_WEIGHT_TWO:   weight_reg[2]   <= pwdata[WEIGHT_BITS-1:0];
                REG_WEIGHT_THREE: weight_reg[3]   <= pwdata[WEIGHT_BITS-1:0];
                REG_WEIGHT_FOUR:  weight_reg[4]   <= pwdata[WEIGHT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HALF_WIDTH:   prdata = APB_DATA_W'(half_width_reg);
            REG_CAUSAL_MODE:  prdata = APB_DATA_W'(causal_mode_reg);
            REG_WEIGHT_CTR:   prdata = APB_DATA_W'(weight_reg[0]);
            REG_WEIGHT_ONE:   prdata = APB_DATA_W'(weight_reg[1]);
            REG_WEIGHT_TWO:   prdata = APB_DATA_W'(weight_reg[2]);
            REG_WEIGHT_THREE: prdata = APB_DATA_W'(weight_reg[3]);
            REG_WEIGHT_FOUR:  prdata = APB_DATA_W'(weight_reg[4]);
            default:          prdata = '0;
        endcase
    end

    assign cfg.half_width  = half_width_reg;
    assign cfg.causal_mode = causal_mode_reg;
    assign cfg.weight      = weight_reg;

    sfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfs_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .sample_in         (sample_in),
        .smoothed          (smoothed),
        .zero_weight_error (zero_weight_error)
    );

endmodule

// File: tb/symmetric_fir_smoothing_tb.sv
// ----------------------------------------------------------------------------
// symmetric_fir_smoothing_tb
// Self-checking bench for the normalised symmetric FIR smoothing filter.
// A short directed list covers reset behaviour, full-scale samples, zero
// weight sum, saturation, clamped half width and causal mode. It is
// followed by segments of random samples, each under a fresh register
// setting. Every output transfer is checked, against a typed expected
// result for some directed rows and otherwise against an in-bench model of
// the delay line and the weighted division. Both handshakes see random stalls.
// ----------------------------------------------------------------------------
module symmetric_fir_smoothing_tb;
    import sfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH      = 2 * MAX_HALF_WIDTH_DEF + 1;
    localparam int          RAND_ITEMS = 1930;
    localparam int          QUIET_TAIL = 150;
    localparam int          LATENCY    = 48;
    localparam logic [2:0]  REG_UNUSED = 3'd7;
    localparam int          SMAX       = 32767;
    localparam int          SMIN       = -32768;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] smoothed;
        logic                              zero_err;
    } result_t;

    typedef struct {
        int                                set_id;
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        bit                                typed;
        result_t                           res;
    } row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [APB_ADDR_W-1:0]             paddr;
    logic [APB_DATA_W-1:0]             pwdata;
    logic [APB_DATA_W-1:0]             prdata;
    logic                              pready;
    logic signed [SAMPLE_BITS_DEF-1:0] sample_in;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [SAMPLE_BITS_DEF-1:0] smoothed;
    logic                              zero_weight_error;
    logic                              out_valid;
    logic                              out_ready;

    cfg_t                              model_cfg;
    logic signed [SAMPLE_BITS_DEF-1:0] model_hist [DEPTH];
    result_t                           pending_smooth [$];

    bit  in_idle_on;
    bit  out_idle_on;
    int  mismatches;
    int  n_items;
    int  n_results;
    int  n_settings;
    int  n_zero;
    int  n_sat;

    symmetric_fir_smoothing i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .sample_in         (sample_in),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .smoothed          (smoothed),
        .zero_weight_error (zero_weight_error),
        .out_valid         (out_valid),
        .out_ready         (out_ready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic cfg_t mk_cfg(int hw, int causal, int w0, int w1, int w2, int w3,
                                    int w4);
        cfg_t c;
        c.half_width  = HALF_WIDTH_BITS'(hw);
        c.causal_mode = causal[0];
        c.weight[0]   = WEIGHT_BITS'(w0);
        c.weight[1]   = WEIGHT_BITS'(w1);
        c.weight[2]   = WEIGHT_BITS'(w2);
        c.weight[3]   = WEIGHT_BITS'(w3);
        c.weight[4]   = WEIGHT_BITS'(w4);
        return c;
    endfunction

    // shift the sample in, weighted sum over the taps in use, then divide by the weight sum and saturate
    function automatic result_t predict_smoothed(logic signed [SAMPLE_BITS_DEF-1:0] x);
        int      h;
        int      taps;
        int      pos;
        int      tap_dist;
        longint  acc;
        longint  wsum;
        longint  w;
        longint  q;
        result_t r;
        for (int i = DEPTH - 1; i > 0; i--)
            model_hist[i] = model_hist[i-1];
        model_hist[0] = x;
        h    = (model_cfg.half_width > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF
                                                           : int'(model_cfg.half_width);
        taps = model_cfg.causal_mode ? h + 1 : 2 * h + 1;
        acc  = 0;
        wsum = 0;
        for (int j = 0; j < taps; j++)
        begin
            if (j <= h)
            begin
                pos      = h - j;
                tap_dist = h - j;
            end
            else
            begin
                pos      = 0;
                tap_dist = j - h;
            end
            if (tap_dist > WEIGHT_COUNT - 1)
                tap_dist = WEIGHT_COUNT - 1;
            w    = longint'($signed(model_cfg.weight[tap_dist]));
            acc  = acc + w * longint'(model_hist[pos]);
            wsum = wsum + w;
        end
        if (wsum == 0)
        begin
            r.smoothed = '0;
            r.zero_err = 1'b1;
            n_zero++;
        end
        else
        begin
            q = acc / wsum;
            if (q > SMAX)
            begin
                q = SMAX;
                n_sat++;
            end
            else if (q < SMIN)
            begin
                q = SMIN;
                n_sat++;
            end
            r.smoothed = q[SAMPLE_BITS_DEF-1:0];
            r.zero_err = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] rand_sample();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else if (sel <= 2)
            return SAMPLE_BITS_DEF'($urandom_range(0, 64) - 32);
        return SAMPLE_BITS_DEF'($urandom);
    endfunction

    function automatic int pick_weight(int mode);
        int sel;
        case (mode)
            1: return $urandom_range(0, 1023) - 512;
            3:
            begin
                sel = $urandom_range(0, 4);
                return (sel == 0) ? -512 : (sel == 1) ? 511 : sel - 3;
            end
            default: return $urandom_range(0, 16) - 8;
        endcase
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        int   mode;
        int   preset;
        int   h;
        int   s;
        int   w0;
        mode = $urandom_range(0, 5);
        c = mk_cfg($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 4),
                   $urandom_range(0, 1), pick_weight(mode), pick_weight(mode),
                   pick_weight(mode), pick_weight(mode), pick_weight(mode));
        if (mode == 0)
        begin
            preset = $urandom_range(0, 5);
            case (preset)
                0: c = mk_cfg(2, c.causal_mode, 17, 12, -3, 0, 0);
                1: c = mk_cfg(4, c.causal_mode, 59, 54, 39, 14, -21);
                2: c = mk_cfg(3, c.causal_mode, 131, 75, -30, 5, 0);
                3: c = mk_cfg(4, c.causal_mode, 179, 135, 30, -55, 15);
                4: c = mk_cfg(4, c.causal_mode, 70, 56, 28, 8, 1);
                default: c = mk_cfg($urandom_range(1, 4), c.causal_mode, 2, 2, 2, 2, 1);
            endcase
        end
        else if (mode >= 4)
        begin
            // force the used weights to sum to zero, or to one
            h = (c.half_width > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF
                                                    : int'(c.half_width);
            s = 0;
            for (int d = 1; d <= h; d++)
                s = s + int'($signed(c.weight[d]));
            if (!c.causal_mode)
                s = 2 * s;
            w0 = (mode == 4) ? -s : 1 - s;
            c.weight[0] = WEIGHT_BITS'(w0);
        end
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_HALF_WIDTH:   model_cfg.half_width  = val[HALF_WIDTH_BITS-1:0];
            REG_CAUSAL_MODE:  model_cfg.causal_mode = val[0];
            REG_WEIGHT_CTR:   model_cfg.weight[0]   = val[WEIGHT_BITS-1:0];
            REG_WEIGHT_ONE:   model_cfg.weight[1]   = val[WEIGHT_BITS-1:0];
            REG_WEIGHT_TWO:   model_cfg.weight[2]   = val[WEIGHT_BITS-1:0];
            REG_WEIGHT_THREE: model_cfg.weight[3]   = val[WEIGHT_BITS-1:0];
            REG_WEIGHT_FOUR:  model_cfg.weight[4]   = val[WEIGHT_BITS-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits are junk on purpose; unused address gets a write too
    task automatic apply_cfg(input cfg_t c);
        write_reg(REG_HALF_WIDTH,   ($urandom & ~32'h7)   | 32'(c.half_width));
        write_reg(REG_CAUSAL_MODE,  ($urandom & ~32'h1)   | 32'(c.causal_mode));
        write_reg(REG_WEIGHT_CTR,   ($urandom & ~32'h3FF) | 32'(c.weight[0]));
        write_reg(REG_WEIGHT_ONE,   ($urandom & ~32'h3FF) | 32'(c.weight[1]));
        write_reg(REG_WEIGHT_TWO,   ($urandom & ~32'h3FF) | 32'(c.weight[2]));
        write_reg(REG_WEIGHT_THREE, ($urandom & ~32'h3FF) | 32'(c.weight[3]));
        write_reg(REG_WEIGHT_FOUR,  ($urandom & ~32'h3FF) | 32'(c.weight[4]));
        write_reg(REG_UNUSED,       $urandom);
        n_settings++;
    endtask

    task automatic wait_idle(input int extra);
        while (pending_smooth.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x, input bit typed,
                               input result_t typed_res);
        result_t r;
        in_valid  <= 1'b1;
        sample_in <= x;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_smoothed(x);
        pending_smooth.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    task automatic maybe_gap();
        if (in_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // receiver stalls
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_idle_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_smooth.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transfer: smoothed %0d zero_weight_error %0d",
                             smoothed, zero_weight_error);
            end
            else
            begin
                e = pending_smooth.pop_front();
                if (smoothed !== e.smoothed || zero_weight_error !== e.zero_err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result %0d: smoothed exp %0d got %0d, %s %0d got %0d",
                                 n_results, e.smoothed, smoothed, "zero_weight_error exp",
                                 e.zero_err, zero_weight_error);
                end
            end
        end
    end

    initial
    begin
        #(30_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        cfg_t    settings [7];
        row_t    directed_rows [21];
        result_t none;
        int      n_rand;
        int      seg_len;

        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        sample_in <= '0;
        in_valid  <= 1'b0;

        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        mismatches  = 0;
        n_items     = 0;
        n_results   = 0;
        n_settings  = 0;
        n_zero      = 0;
        n_sat       = 0;
        none        = '0;
        model_cfg   = mk_cfg(2, 0, 1, 1, 1, 1, 1);
        foreach (model_hist[i])
            model_hist[i] = '0;

        settings[0] = mk_cfg(1, 0, 2, -1, 1, 1, 1);        // weights sum to zero
        settings[1] = mk_cfg(1, 1, 511, -510, 1, 1, 1);    // sum one, saturates
        settings[2] = mk_cfg(7, 0, 70, 56, 28, 8, 1);      // half width clamps to four
        settings[3] = mk_cfg(0, 0, -512, 0, 0, 0, 0);      // pass-through
        settings[4] = mk_cfg(0, 1, 0, 5, 5, 5, 5);         // single zero tap
        settings[5] = mk_cfg(4, 1, 511, -512, 511, -512, 511);
        settings[6] = mk_cfg(4, 0, -512, -512, -512, -512, -512);

        directed_rows = '{
            '{-1, 16'sd0,      1'b1, '{16'sd0, 1'b0}},
            '{-1, 16'sh7FFF,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh8000,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sd1,      1'b0, '{16'sd0, 1'b0}},
            '{-1, -16'sd1,     1'b0, '{16'sd0, 1'b0}},
            '{ 0, 16'sd12345,  1'b1, '{16'sd0, 1'b1}},
            '{-1, 16'sh8000,   1'b1, '{16'sd0, 1'b1}},
            '{ 1, 16'sh8000,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh7FFF,   1'b1, '{16'sh7FFF, 1'b0}},
            '{-1, 16'sh8000,   1'b1, '{16'sh8000, 1'b0}},
            '{ 2, 16'sd100,    1'b0, '{16'sd0, 1'b0}},
            '{-1, -16'sd200,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh7FFF,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh8000,   1'b0, '{16'sd0, 1'b0}},
            '{ 3, 16'sh8000,   1'b1, '{16'sh8000, 1'b0}},
            '{-1, 16'sh7FFF,   1'b1, '{16'sh7FFF, 1'b0}},
            '{ 4, 16'sh5A5A,   1'b1, '{16'sd0, 1'b1}},
            '{ 5, 16'sh7FFF,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh8000,   1'b0, '{16'sd0, 1'b0}},
            '{ 6, 16'sh7FFF,   1'b0, '{16'sd0, 1'b0}},
            '{-1, 16'sh8000,   1'b0, '{16'sd0, 1'b0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_id >= 0)
            begin
                in_valid <= 1'b0;
                wait_idle(4);
                apply_cfg(settings[directed_rows[i].set_id]);
            end
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].res);
            maybe_gap();
        end

        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            in_valid <= 1'b0;
            wait_idle(4);
            apply_cfg(rand_cfg());
            in_idle_on  = $urandom_range(0, 4) != 0;
            out_idle_on = $urandom_range(0, 4) != 0;
            seg_len = $urandom_range(10, 120);
            for (int k = 0; k < seg_len && n_rand < RAND_ITEMS; k++)
            begin
                if (RAND_ITEMS - n_rand <= QUIET_TAIL)
                begin
                    in_idle_on  = 1'b0;
                    out_idle_on = 1'b0;
                end
                send_sample(rand_sample(), 1'b0, none);
                n_rand++;
                maybe_gap();
            end
        end
        in_valid <= 1'b0;

        wait_idle(LATENCY);
        $display("Covered %0d samples under %0d register settings, random stalls on both sides",
                 n_items, n_settings);
        $display("%0d results checked, %0d with zero weight sum, %0d saturated",
                 n_results, n_zero, n_sat);
        if (mismatches == 0 && pending_smooth.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
